// File: sv/pfe_pkg.sv
// Shared types and constants for the Playfair stream encryptor.
`default_nettype none
package pfe_pkg;

  localparam int CELL_COUNT = 25;
  localparam int SIDE = 5;
  localparam int CODE_W = 5;
  localparam int POS_W = 5;
  localparam int ROWCOL_W = 3;
  localparam int LOW_W = 50;
  localparam int MID_W = 50;
  localparam int HIGH_W = 25;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] CHAR_A = 8'd65;
  localparam logic [7:0] CHAR_Z = 8'd90;
  localparam logic [CODE_W-1:0] CODE_X = 5'd23;
  localparam logic [CODE_W-1:0] CODE_J = 5'd9;
  localparam logic [CODE_W-1:0] CODE_I = 5'd8;

  typedef enum logic [1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_MID  = 2'd1,
    CFG_KEY_HIGH = 2'd2
  } cfg_index_t;

  typedef logic [CELL_COUNT-1:0][CODE_W-1:0] key_square_t;

  typedef struct packed {
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] second;
    logic              has_pair;
    logic              last;
  } job_t;

  typedef struct packed {
    logic [1:0] count;
    job_t       job0;
    job_t       job1;
  } push_t;

endpackage
`default_nettype wire

// File: sv/pfe_front.sv
// Front end: filters letters, inserts doubling X, forms pairs and end markers.
`default_nettype none
module pfe_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   in_char,
  input  wire logic         in_last,
  output pfe_pkg::push_t    push
);
  import pfe_pkg::*;

  logic [CODE_W-1:0] pending_code;
  logic              pending_valid;
  logic [CODE_W-1:0] previous_code;
  logic              previous_valid;

  logic              is_letter;
  logic [CODE_W-1:0] code;
  logic              doubled;
  logic [1:0]        count;
  job_t              job0;
  job_t              job1;
  logic [CODE_W-1:0] pc;
  logic              pv;

  always_comb begin
    is_letter = (in_char >= CHAR_A) && (in_char <= CHAR_Z);
    code = CODE_W'(in_char - CHAR_A);
    doubled = is_letter && previous_valid && (code == previous_code);
    count = 2'd0;
    job0 = '0;
    job1 = '0;
    pc = pending_code;
    pv = pending_valid;
    if (is_letter) begin
      if (doubled) begin
        if (pv) begin
          job0 = '{first: pc, second: CODE_X, has_pair: 1'b1, last: 1'b0};
          count = 2'd1;
          pc = code;
        end else begin
          job0 = '{first: CODE_X, second: code, has_pair: 1'b1, last: 1'b0};
          count = 2'd1;
          pv = 1'b0;
        end
      end else if (pv) begin
        job0 = '{first: pc, second: code, has_pair: 1'b1, last: 1'b0};
        count = 2'd1;
        pv = 1'b0;
      end else begin
        pc = code;
        pv = 1'b1;
      end
    end
    if (in_last) begin
      if (pv) begin
        if (count == 2'd0) begin
          job0 = '{first: pc, second: CODE_X, has_pair: 1'b1, last: 1'b1};
          count = 2'd1;
        end else begin
          job1 = '{first: pc, second: CODE_X, has_pair: 1'b1, last: 1'b1};
          count = 2'd2;
        end
      end else if (count == 2'd0) begin
        job0 = '{first: '0, second: '0, has_pair: 1'b0, last: 1'b1};
        count = 2'd1;
      end else begin
        job0.last = 1'b1;
      end
    end
    push.count = accept ? count : 2'd0;
    push.job0 = job0;
    push.job1 = job1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_code <= '0;
      pending_valid <= 1'b0;
      previous_code <= '0;
      previous_valid <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        pending_code <= '0;
        pending_valid <= 1'b0;
        previous_code <= '0;
        previous_valid <= 1'b0;
      end else begin
        pending_code <= pc;
        pending_valid <= pv;
        if (is_letter) begin
          previous_code <= code;
          previous_valid <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/pfe_queue.sv
// Small job queue between front and back, taking up to two jobs per cycle.
`default_nettype none
module pfe_queue (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire pfe_pkg::push_t          push,
  input  wire logic                    pop,
  output pfe_pkg::job_t                head,
  output logic                         not_empty,
  output logic                         room_for_two
);
  import pfe_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              do_pop;

  assign head = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign room_for_two = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign do_pop = pop && not_empty;

  always_comb begin
    count_next = count + QCNT_W'(push.count) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.job0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.job1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(do_pop);
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/pfe_back.sv
// Back end: finds pairs in the key square; emits two letters or an end marker.
`default_nettype none
module pfe_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pfe_pkg::key_square_t cells,
  input  wire pfe_pkg::job_t        head,
  input  wire logic                 head_valid,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_char,
  output logic                      has_char,
  output logic                      out_last
);
  import pfe_pkg::*;

  function automatic logic [ROWCOL_W*2-1:0] locate(
    input key_square_t sq,
    input logic [CODE_W-1:0] letter
  );
    logic [CODE_W-1:0]   want;
    logic [ROWCOL_W-1:0] row;
    logic [ROWCOL_W-1:0] col;
    want = (letter == CODE_J) ? CODE_I : letter;
    row = '0;
    col = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (sq[r * SIDE + c] == want) begin
          row = ROWCOL_W'(r);
          col = ROWCOL_W'(c);
        end
      end
    end
    return {row, col};
  endfunction

  function automatic logic [POS_W-1:0] cell_pos(
    input logic [ROWCOL_W-1:0] row,
    input logic [ROWCOL_W-1:0] col
  );
    return POS_W'((POS_W'(row) << 2) + POS_W'(row) + POS_W'(col));
  endfunction

  function automatic logic [ROWCOL_W-1:0] step5(input logic [ROWCOL_W-1:0] v);
    return (v == ROWCOL_W'(SIDE - 1)) ? '0 : v + ROWCOL_W'(1);
  endfunction

  logic [ROWCOL_W*2-1:0] loc1;
  logic [ROWCOL_W*2-1:0] loc2;
  logic [ROWCOL_W-1:0]   r1, c1, r2, c2;
  logic [POS_W-1:0]      p1_next;
  logic [POS_W-1:0]      p2_next;

  logic                  work_valid;
  logic                  work_phase;
  logic                  work_has;
  logic                  work_last;
  logic [POS_W-1:0]      p1;
  logic [POS_W-1:0]      p2;
  logic                  out_load;
  logic                  work_done;
  logic [CODE_W-1:0]     sel_code;

  always_comb begin
    loc1 = locate(cells, head.first);
    loc2 = locate(cells, head.second);
    r1 = loc1[ROWCOL_W*2-1:ROWCOL_W];
    c1 = loc1[ROWCOL_W-1:0];
    r2 = loc2[ROWCOL_W*2-1:ROWCOL_W];
    c2 = loc2[ROWCOL_W-1:0];
    if (r1 == r2) begin
      p1_next = cell_pos(r1, step5(c1));
      p2_next = cell_pos(r2, step5(c2));
    end else if (c1 == c2) begin
      p1_next = cell_pos(step5(r1), c1);
      p2_next = cell_pos(step5(r2), c2);
    end else begin
      p1_next = cell_pos(r1, c2);
      p2_next = cell_pos(r2, c1);
    end
  end

  assign out_load = !out_valid || !out_stall;
  assign work_done = work_valid && out_load && (work_phase || !work_has);
  assign pop = head_valid && (!work_valid || work_done);
  assign sel_code = work_phase ? cells[p2] : cells[p1];

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      work_phase <= 1'b0;
    end else if (pop) begin
      work_valid <= 1'b1;
      work_phase <= 1'b0;
    end else if (work_done) begin
      work_valid <= 1'b0;
      work_phase <= 1'b0;
    end else if (work_valid && out_load) begin
      work_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p1 <= p1_next;
      p2 <= p2_next;
      work_has <= head.has_pair;
      work_last <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && work_valid) begin
      if (work_has) begin
        out_char <= CHAR_A + 8'(sel_code);
        has_char <= 1'b1;
        out_last <= work_phase && work_last;
      end else begin
        out_char <= '0;
        has_char <= 1'b0;
        out_last <= work_last;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/playfair_stream_encrypt.sv
// Playfair stream encryptor top level: key registers, front end, job queue, back end.
// Plaintext bytes enter on in_char/in_last with in_valid; a transfer happens on a
// rising edge with in_valid high and in_stall low. Bytes outside A..Z are dropped,
// a repeated letter gets an X inserted before it, and in_last pads an odd letter
// with X. Each pair gives two cipher letters on out_char with has_char set; a
// message end that yields no letter gives one result with has_char low.
// out_last marks the final result of each message. Results transfer when out_valid
// is high and out_stall is low.
// The key square is written through cfg_valid/cfg_ready/cfg_index/cfg_data:
// index 0 holds cells 0 to 9, index 1 cells 10 to 19, index 2 cells 20 to 24,
// five bits per cell, row-major. Write it only while the block is idle.
// With the queue and back end empty, the pair a byte completes is written into the
// queue, then into the back end's work registers, then into the output register,
// which raises out_valid. One byte is taken per cycle while the four-entry job
// queue has two free slots; the output register gives one result per cycle while
// out_stall is low. Without stalls ordinary text sustains about one byte per cycle;
// in a run of repeated letters every byte completes a pair and gives two results.
// When the receiver stalls, the output holds, the queue fills, and in_stall rises.
// Reset clears the queue, the pairing state and the key square to all zero codes.
`default_nettype none
module playfair_stream_encrypt (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_char,
  input  wire logic         in_last,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_char,
  output logic              has_char,
  output logic              out_last,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [49:0]  cfg_data
);
  import pfe_pkg::*;

  logic [LOW_W-1:0]  key_cells_low;
  logic [MID_W-1:0]  key_cells_mid;
  logic [HIGH_W-1:0] key_cells_high;
  key_square_t       cells;
  push_t             push;
  job_t              head;
  logic              head_valid;
  logic              room_for_two;
  logic              pop;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign cells = {key_cells_high, key_cells_mid, key_cells_low};
  assign in_stall = !room_for_two;
  assign accept = in_valid && room_for_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_cells_low <= '0;
      key_cells_mid <= '0;
      key_cells_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_cells_low <= cfg_data[LOW_W-1:0];
        CFG_KEY_MID:  key_cells_mid <= cfg_data[MID_W-1:0];
        CFG_KEY_HIGH: key_cells_high <= cfg_data[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  pfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_char (in_char),
    .in_last (in_last),
    .push    (push)
  );

  pfe_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pop          (pop),
    .head         (head),
    .not_empty    (head_valid),
    .room_for_two (room_for_two)
  );

  pfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cells      (cells),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .has_char   (has_char),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

// File: verif/tb_playfair_stream_encrypt.sv
// Self-checking testbench for playfair_stream_encrypt with a built-in Playfair predictor.
module tb_playfair_stream_encrypt;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  localparam logic [7:0] LETTER_X = "X";
  localparam logic [7:0] LETTER_I = "I";
  localparam logic [7:0] LETTER_J = "J";
  localparam logic [7:0] LETTER_SPACE = " ";
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam logic [49:0] CELLS_ALL_ONES = '1;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
  } cipher_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain_first;
  } plain_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        has_char;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_KEY_LOW;
  logic [49:0] cfg_data = '0;

  plain_t      plain_queue[$];
  cipher_t     cipher_expect[$];
  plain_t      next_plain;
  cipher_t     oldest_cipher;
  bit          in_taken = 1'b0;
  bit          hold_for_drain = 1'b0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_request = 1'b0;
  bit          hold_served = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          errors = 0;

  logic [49:0] key_low = '0;
  logic [49:0] key_mid = '0;
  logic [24:0] key_high = '0;
  logic [7:0]  held_letter = '0;
  bit          held_valid = 1'b0;
  logic [7:0]  last_plain = '0;
  bit          last_plain_valid = 1'b0;
  logic [4:0]  square_codes [CELL_COUNT];

  playfair_stream_encrypt i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .has_char  (has_char),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic logic [4:0] cell_code(input int p);
    if (p < 10) return key_low[5*p +: 5];
    if (p < 20) return key_mid[5*(p-10) +: 5];
    return key_high[5*(p-20) +: 5];
  endfunction

  function automatic void find_cell(input logic [7:0] letter, output int row, output int col);
    logic [7:0] code;
    int p;
    if (letter == LETTER_J) letter = LETTER_I;
    code = letter - CHAR_A;
    row = 0;
    col = 0;
    for (p = 0; p < CELL_COUNT; p++) begin
      if ({3'b000, cell_code(p)} == code) begin
        row = p / SIDE;
        col = p % SIDE;
        return;
      end
    end
  endfunction

  function automatic void encipher_pair(input logic [7:0] a, input logic [7:0] b);
    int r1, c1, r2, c2, p1, p2;
    find_cell(a, r1, c1);
    find_cell(b, r2, c2);
    if (r1 == r2) begin
      p1 = r1 * SIDE + (c1 + 1) % SIDE;
      p2 = r2 * SIDE + (c2 + 1) % SIDE;
    end else if (c1 == c2) begin
      p1 = ((r1 + 1) % SIDE) * SIDE + c1;
      p2 = ((r2 + 1) % SIDE) * SIDE + c2;
    end else begin
      p1 = r1 * SIDE + c2;
      p2 = r2 * SIDE + c1;
    end
    cipher_expect.push_back('{8'(CHAR_A + cell_code(p1)), 1'b1, 1'b0});
    cipher_expect.push_back('{8'(CHAR_A + cell_code(p2)), 1'b1, 1'b0});
  endfunction

  function automatic void place_letter(input logic [7:0] letter);
    if (held_valid) begin
      encipher_pair(held_letter, letter);
      held_valid = 1'b0;
      held_letter = '0;
    end else begin
      held_letter = letter;
      held_valid = 1'b1;
    end
  endfunction

  function automatic void predict_cipher(input logic [7:0] ch, input logic last);
    int count_at_entry;
    cipher_t tail;
    count_at_entry = cipher_expect.size();
    if (ch >= CHAR_A && ch <= CHAR_Z) begin
      if (last_plain_valid && ch == last_plain) place_letter(LETTER_X);
      place_letter(ch);
      last_plain = ch;
      last_plain_valid = 1'b1;
    end
    if (last) begin
      if (held_valid) encipher_pair(held_letter, LETTER_X);
      held_letter = '0;
      held_valid = 1'b0;
      last_plain = '0;
      last_plain_valid = 1'b0;
      if (cipher_expect.size() == count_at_entry) begin
        cipher_expect.push_back('{8'd0, 1'b0, 1'b1});
      end else begin
        tail = cipher_expect.pop_back();
        tail.last = 1'b1;
        cipher_expect.push_back(tail);
      end
    end
  endfunction

  // Plaintext driver: a payload stays put until its transfer is seen.
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
    end else if (plain_queue.size() != 0 &&
                 !(plain_queue[0].drain_first && cipher_expect.size() != 0) &&
                 $urandom_range(0, 99) >= idle_pct) begin
      next_plain = plain_queue.pop_front();
      in_valid <= 1'b1;
      in_char <= next_plain.ch;
      in_last <= next_plain.last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_request && !hold_served) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_served = 1'b1;
    end
    if (!hold_request) hold_served = 1'b0;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (cipher_expect.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, %s %02h has_char %0d out_last %0d",
                 $time, "actual out_char", out_char, has_char, out_last);
      end else begin
        oldest_cipher = cipher_expect.pop_front();
        if (out_char !== oldest_cipher.ch) begin
          errors++;
          $display("%0t out_char mismatch: expected %02h actual %02h",
                   $time, oldest_cipher.ch, out_char);
        end
        if (has_char !== oldest_cipher.has) begin
          errors++;
          $display("%0t has_char mismatch: expected %0d actual %0d",
                   $time, oldest_cipher.has, has_char);
        end
        if (out_last !== oldest_cipher.last) begin
          errors++;
          $display("%0t out_last mismatch: expected %0d actual %0d",
                   $time, oldest_cipher.last, out_last);
        end
      end
    end
    if (!rst && in_valid && !in_stall) predict_cipher(in_char, in_last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_playfair_stream_encrypt NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_key(input cfg_index_t idx, input logic [49:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_LOW:  key_low = value;
      CFG_KEY_MID:  key_mid = value;
      CFG_KEY_HIGH: key_high = value[HIGH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_square();
    logic [49:0] low, mid, high;
    int p;
    low = '0;
    mid = '0;
    high = '0;
    for (p = 0; p < CELL_COUNT; p++) begin
      if (p < 10) low[5*p +: 5] = square_codes[p];
      else if (p < 20) mid[5*(p-10) +: 5] = square_codes[p];
      else high[5*(p-20) +: 5] = square_codes[p];
    end
    write_key(CFG_KEY_LOW, low);
    write_key(CFG_KEY_MID, mid);
    write_key(CFG_KEY_HIGH, high);
  endtask

  // Random square drawn from all 26 letters, so one letter is always absent.
  task automatic shuffle_square();
    logic [4:0] pool [26];
    logic [4:0] swap;
    int i, j;
    for (i = 0; i < 26; i++) pool[i] = 5'(i);
    for (i = 25; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = pool[i];
      pool[i] = pool[j];
      pool[j] = swap;
    end
    for (i = 0; i < CELL_COUNT; i++) square_codes[i] = pool[i];
  endtask

  task automatic add_plain(input logic [7:0] ch, input logic last);
    plain_queue.push_back('{ch, last, hold_for_drain});
    hold_for_drain = 1'b0;
  endtask

  task automatic add_message(input bit force_end);
    int body, kind, i;
    logic [7:0] ch, prev_ch;
    logic last;
    body = $urandom_range(0, 11);
    prev_ch = "A";
    for (i = 0; i <= body; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) ch = prev_ch;
      else if (kind < 18) ch = LETTER_SPACE;
      else if (kind < 22) ch = 8'($urandom_range(0, 255));
      else if (kind < 25) ch = LETTER_I;
      else if (kind < 28) ch = LETTER_J;
      else ch = 8'(CHAR_A + $urandom_range(0, 25));
      last = (i == body) && (force_end || $urandom_range(0, 9) != 0);
      add_plain(ch, last);
      if (ch >= CHAR_A && ch <= CHAR_Z) prev_ch = ch;
    end
  endtask

  task automatic settle();
    do @(posedge clk); while (plain_queue.size() != 0 || in_valid || cipher_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int sender_idle, input int rx_stall, input int budget,
                           input bit rx_hold, input bit tx_pause);
    bit paused;
    paused = 1'b0;
    idle_pct = sender_idle;
    stall_pct = rx_stall;
    hold_request = rx_hold;
    while (plain_queue.size() < budget) begin
      if (tx_pause && !paused && plain_queue.size() >= budget / 2) begin
        hold_for_drain = 1'b1;
        paused = 1'b1;
      end
      add_message(1'b0);
    end
    add_message(1'b1);
    settle();
    hold_request = 1'b0;
  endtask

  initial begin
    string keyword;
    logic [63:0] raw;
    int i;
    keyword = "PLAYFIREXMBCDGHKNOQSTUVWZ";
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The square is all zero codes out of reset.
    add_plain("K", 1'b0);
    add_plain("A", 1'b1);
    settle();

    for (i = 0; i < CELL_COUNT; i++) square_codes[i] = 5'(keyword[i] - CHAR_A);
    write_square();
    add_plain("A", 1'b0);
    add_plain("Y", 1'b0);
    add_plain("P", 1'b0);
    add_plain("B", 1'b0);
    add_plain("L", 1'b0);
    add_plain("H", 1'b0);
    add_plain("I", 1'b0);
    add_plain("J", 1'b0);
    add_plain(8'h00, 1'b0);
    add_plain(8'hFF, 1'b0);
    add_plain("L", 1'b0);
    add_plain("L", 1'b0);
    add_plain("@", 1'b0);
    add_plain("[", 1'b0);
    add_plain("Z", 1'b1);
    add_plain(LETTER_SPACE, 1'b1);
    add_plain("Q", 1'b0);
    add_plain("Q", 1'b1);
    add_plain("X", 1'b0);
    add_plain("X", 1'b0);
    add_plain("M", 1'b0);
    add_plain("D", 1'b0);
    add_plain(LETTER_SPACE, 1'b1);
    settle();

    run_phase(47, 0, 30, 1'b0, 1'b0);

    // Codes of 31 never match a letter and come out past Z.
    write_key(CFG_KEY_LOW, CELLS_ALL_ONES);
    write_key(CFG_KEY_MID, CELLS_ALL_ONES);
    write_key(CFG_KEY_HIGH, CELLS_ALL_ONES);
    run_phase(0, 47, 20, 1'b0, 1'b0);

    write_key(CFG_KEY_LOW, '0);
    write_key(CFG_KEY_MID, '0);
    write_key(CFG_KEY_HIGH, '0);
    run_phase(35, 35, 15, 1'b0, 1'b0);

    shuffle_square();
    write_square();
    run_phase(35, 35, 40, 1'b1, 1'b1);

    raw = {$urandom, $urandom};
    write_key(CFG_KEY_LOW, raw[49:0]);
    raw = {$urandom, $urandom};
    write_key(CFG_KEY_MID, raw[49:0]);
    raw = {$urandom, $urandom};
    write_key(CFG_KEY_HIGH, raw[49:0]);
    run_phase(0, 47, 25, 1'b0, 1'b0);

    shuffle_square();
    write_square();
    run_phase(0, 0, 40, 1'b1, 1'b0);

    if (errors == 0) begin
      $display("tb_playfair_stream_encrypt OK");
    end else begin
      $display("tb_playfair_stream_encrypt NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pfe_pkg.sv
sv/pfe_front.sv
sv/pfe_queue.sv
sv/pfe_back.sv
sv/playfair_stream_encrypt.sv
verif/tb_playfair_stream_encrypt.sv
